[hdl/rfr_pkg.sv]
// ----------------------------------------------------------------------------
// rfr_pkg: shared definitions for the RGBA fade ramp
// Fixed-point widths, reciprocal constants, register indexes, reset values,
// the control word layout and the microcode program of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rfr_pkg;

  // Fixed-point format of one color channel: 8 integer bits, FRAC_BITS fraction.
  localparam int FRAC_BITS = 16;
  localparam int CH_W      = FRAC_BITS + 8;
  localparam int NUM_CH    = 4;

  // Port field widths.
  localparam int ELAPSED_W = 16;
  localparam int SPEED_W   = 24;
  localparam int COLOR_W   = 32;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;

  // speed * elapsed, then channel distance * (speed * elapsed).
  localparam int T_W    = SPEED_W + ELAPSED_W;
  localparam int PROD_W = T_W + BYTE_W;

  // Step = (distance * speed * elapsed << SHL) / DIV, quotient kept to CH_W bits.
  localparam int SHL   = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
  localparam int DIV   = 1000 << ((FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0);
  localparam int DVD_W = PROD_W + SHL;

  // DIV is the odd factor 125 times a power of two. The power of two is a
  // shift; the odd factor is removed by multiplying with its reciprocal,
  // rounded up, which is exact for every dividend below 125 << CH_W.
  localparam int ODD_DIV = 125;
  localparam int DIV_SH  = 3 + ((FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0);
  localparam int X_W     = CH_W + 7;
  localparam int RSH     = X_W + 7;
  localparam int RECIP_W = X_W + 1;
  localparam int QP_W    = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RSH) + 64'(ODD_DIV - 1)) / 64'(ODD_DIV));
  localparam logic [DVD_W-1:0]   QOVF  = DVD_W'(ODD_DIV) << CH_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_END_COLOR   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_COLOR = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPEED       = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE = CFG_IDX_W'(4);

  // Register reset values.
  localparam logic [COLOR_W-1:0] START_COLOR_RST = 32'h0000_0000;
  localparam logic [COLOR_W-1:0] END_COLOR_RST   = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] FINAL_COLOR_RST = 32'hFFFF_FFFF;
  localparam logic [SPEED_W-1:0] SPEED_RST       = 24'h01_0000;
  localparam logic               LOOP_RST        = 1'b0;

  // Datapath operation selected by the control word.
  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_MUL_T,
    OP_MUL_P,
    OP_SCALE,
    OP_RECIP,
    OP_APPLY,
    OP_RESTART,
    OP_EMIT
  } op_t;

  // Jump condition selected by the control word.
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_IN,
    COND_RESTART,
    COND_DONE,
    COND_OUT_BUSY
  } cond_t;

  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  // Program step addresses.
  localparam pc_t STEP_IDLE    = PC_W'(0);
  localparam pc_t STEP_MUL_T   = PC_W'(1);
  localparam pc_t STEP_MUL_P   = PC_W'(2);
  localparam pc_t STEP_SCALE   = PC_W'(3);
  localparam pc_t STEP_RECIP   = PC_W'(4);
  localparam pc_t STEP_APPLY   = PC_W'(5);
  localparam pc_t STEP_RESTART = PC_W'(6);
  localparam pc_t STEP_EMIT    = PC_W'(7);

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctl_t;

  // Status flags the sequencer branches on.
  typedef struct packed {
    logic no_in;
    logic restart;
    logic done;
    logic out_busy;
  } stat_t;

  // Microcode program. A taken jump loads target, otherwise the step counter
  // advances by one and wraps from the last step back to the idle step.
  function automatic ctl_t ucode_rom(input pc_t pc);
    ctl_t w;
    unique case (pc)
      STEP_IDLE:    w = '{op: OP_ACCEPT,  cond: COND_NO_IN,    target: STEP_IDLE};
      STEP_MUL_T:   w = '{op: OP_MUL_T,   cond: COND_RESTART,  target: STEP_RESTART};
      STEP_MUL_P:   w = '{op: OP_MUL_P,   cond: COND_DONE,     target: STEP_EMIT};
      STEP_SCALE:   w = '{op: OP_SCALE,   cond: COND_NEXT,     target: STEP_IDLE};
      STEP_RECIP:   w = '{op: OP_RECIP,   cond: COND_NEXT,     target: STEP_IDLE};
      STEP_APPLY:   w = '{op: OP_APPLY,   cond: COND_ALWAYS,   target: STEP_EMIT};
      STEP_RESTART: w = '{op: OP_RESTART, cond: COND_NEXT,     target: STEP_IDLE};
      STEP_EMIT:    w = '{op: OP_EMIT,    cond: COND_OUT_BUSY, target: STEP_EMIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hdl/rfr_seq.sv]
// ----------------------------------------------------------------------------
// rfr_seq: microcode sequencer
// Holds the step counter, reads the control word from the program table
// and resolves conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module rfr_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rfr_pkg::stat_t stat,
  output rfr_pkg::op_t       op
);
  import rfr_pkg::*;

  pc_t  pc_r, pc_nxt;
  ctl_t ctl;
  logic jump;

  // Control word of the current step.
  assign ctl = ucode_rom(pc_r);
  assign op  = ctl.op;

  // Jump condition.
  always_comb begin
    unique case (ctl.cond)
      COND_NEXT:     jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_IN:    jump = stat.no_in;
      COND_RESTART:  jump = stat.restart;
      COND_DONE:     jump = stat.done;
      COND_OUT_BUSY: jump = stat.out_busy;
      default:       jump = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    pc_nxt = jump ? ctl.target : pc_r + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A waiting tick always leaves the idle step for the first multiply.
  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_ACCEPT && !stat.no_in) |=> (op == OP_MUL_T))
    else $error("pending tick did not start the program");

  // The emit step holds while the output register is still occupied.
  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_EMIT && stat.out_busy) |=> (op == OP_EMIT))
    else $error("emit step left with the output busy");

  // The reciprocal multiply hands over to the channel update.
  a_recip_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_RECIP) |=> (op == OP_APPLY))
    else $error("reciprocal step did not exit to apply");
`endif

endmodule

`default_nettype wire

[hdl/rfr_lane.sv]
// ----------------------------------------------------------------------------
// rfr_lane: one color channel
// Holds the current channel value, multiplies the channel distance by the
// shared speed * elapsed product, divides by the time base with a shift and
// a reciprocal multiply and moves the channel toward its target with clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module rfr_lane (
  input  wire logic                          clk,
  input  wire rfr_pkg::op_t                  op,
  input  wire logic [rfr_pkg::BYTE_W-1:0]    from_byte,
  input  wire logic [rfr_pkg::BYTE_W-1:0]    to_byte,
  input  wire logic [rfr_pkg::T_W-1:0]       t_prod,
  input  wire logic                          load_en,
  input  wire logic [rfr_pkg::BYTE_W-1:0]    load_byte,
  output logic      [rfr_pkg::CH_W-1:0]      cur,
  output logic                               at_target
);
  import rfr_pkg::*;

  logic [CH_W-1:0]   cur_r;
  logic [PROD_W-1:0] p_r;
  logic [X_W-1:0]    x_r;
  logic [CH_W-1:0]   q_r;
  logic              ovf_r;

  logic              up, down;
  logic [BYTE_W-1:0] mag;
  logic [DVD_W-1:0]  dvd;
  logic [DVD_W-1:0]  scaled;
  logic [QP_W-1:0]   qprod;
  logic [CH_W-1:0]   step;
  logic [CH_W-1:0]   tfix;
  logic [CH_W:0]     sum;
  logic [CH_W-1:0]   c_new;

  // Direction and distance between the endpoints.
  assign up   = (to_byte > from_byte);
  assign down = (to_byte < from_byte);
  assign mag  = up ? (to_byte - from_byte) : (from_byte - to_byte);

  // Dividend with the power-of-two part of the time base shifted out.
  assign dvd    = DVD_W'(p_r) << SHL;
  assign scaled = dvd >> DIV_SH;

  // Division by the odd factor as a multiply by its reciprocal.
  assign qprod = QP_W'(x_r) * QP_W'(RECIP);

  // A quotient that overflows the channel width always reaches the target.
  assign step = ovf_r ? '1 : q_r;
  assign tfix = {to_byte, {FRAC_BITS{1'b0}}};
  assign sum  = {1'b0, cur_r} + {1'b0, step};

  // Move toward the target, clamped at it.
  always_comb begin
    c_new = cur_r;
    if (up) begin
      c_new = (sum > {1'b0, tfix}) ? tfix : sum[CH_W-1:0];
    end else if (down) begin
      if (cur_r < step) begin
        c_new = tfix;
      end else begin
        c_new = ((cur_r - step) < tfix) ? tfix : (cur_r - step);
      end
    end
  end

  assign at_target = (c_new == tfix);
  assign cur       = cur_r;

  // Arithmetic registers.
  always_ff @(posedge clk) begin
    unique case (op)
      OP_MUL_P: begin
        p_r <= PROD_W'(mag) * PROD_W'(t_prod);
      end
      OP_SCALE: begin
        ovf_r <= (scaled >= QOVF);
        x_r   <= scaled[X_W-1:0];
      end
      OP_RECIP: begin
        q_r <= qprod[RSH+CH_W-1:RSH];
      end
      default: begin
      end
    endcase
  end

  // Current channel value.
  always_ff @(posedge clk) begin
    if (load_en) begin
      cur_r <= {load_byte, {FRAC_BITS{1'b0}}};
    end else if (op == OP_APPLY) begin
      cur_r <= c_new;
    end
  end

endmodule

`default_nettype wire

[hdl/rgba_fade_ramp.sv]
// ----------------------------------------------------------------------------
// rgba_fade_ramp: linear RGBA color fade with optional ping-pong
// Top level: configuration registers, endpoint colors, the shared
// speed * elapsed multiply, four channel lanes and the output register.
// ----------------------------------------------------------------------------
// Each accepted tick moves the four 8.16 color channels from the from color
// toward the to color by distance * speed * elapsed_ms / 1000 and returns one
// result. A moving tick runs these steps before the next tick can be taken:
// accept, the speed * elapsed multiply, the distance multiply, a scaling step,
// a reciprocal multiply that stands in for the division by 1000, the channel
// update and the emit step. A restart tick, or a tick after a non-looping fade
// has ended, leaves out the scaling, reciprocal and update steps. The emit
// step waits while the output register still holds an untransferred result;
// once it has loaded the result, the next tick can be taken while that result
// is pending. Configuration writes are taken every cycle; a write to
// start_color or end_color restarts the fade from start_color.
`default_nettype none

module rgba_fade_ramp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Tick input.
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [rfr_pkg::ELAPSED_W-1:0]    in_elapsed_ms,
  input  wire logic                             in_restart,
  // Result output.
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [rfr_pkg::BYTE_W-1:0]       out_red,
  output logic      [rfr_pkg::BYTE_W-1:0]       out_green,
  output logic      [rfr_pkg::BYTE_W-1:0]       out_blue,
  output logic      [rfr_pkg::BYTE_W-1:0]       out_alpha,
  output logic                                  out_ended,
  output logic                                  out_reversed,
  // Configuration writes.
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rfr_pkg::COLOR_W-1:0]      cfg_data
);
  import rfr_pkg::*;

  op_t   op;
  stat_t stat;

  // Configuration registers.
  logic [COLOR_W-1:0] start_r, start_nxt;
  logic [COLOR_W-1:0] end_r, end_nxt;
  logic [COLOR_W-1:0] final_r, final_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic               loop_r, loop_nxt;
  logic               reinit;

  // Fade state.
  logic [COLOR_W-1:0] from_r, from_nxt;
  logic [COLOR_W-1:0] to_r, to_nxt;
  logic               done_r, done_nxt;
  logic               rev_r, rev_nxt;

  // Captured tick and shared product.
  logic [ELAPSED_W-1:0] ms_r;
  logic                 restart_r;
  logic [T_W-1:0]       t_r;

  // Lane interface.
  logic               load_en;
  logic [COLOR_W-1:0] load_color;
  logic [CH_W-1:0]    cur [NUM_CH];
  logic [NUM_CH-1:0]  at_target;
  logic               reached;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic               out_busy;
  logic               emit_fire;
  logic               in_xfer;
  logic               cfg_xfer;

  assign in_ready  = (op == OP_ACCEPT);
  assign in_xfer   = in_valid & in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid & cfg_ready;
  assign out_busy  = out_valid_r & ~out_ready;
  assign emit_fire = (op == OP_EMIT) & ~out_busy;
  assign reached   = &at_target;

  assign stat = '{no_in: ~in_valid, restart: restart_r, done: done_r, out_busy: out_busy};

  rfr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  // Configuration register writes.
  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    final_nxt = final_r;
    speed_nxt = speed_r;
    loop_nxt  = loop_r;
    reinit    = 1'b0;
    if (cfg_xfer) begin
      unique case (cfg_index)
        REG_START_COLOR: begin
          start_nxt = cfg_data;
          reinit    = 1'b1;
        end
        REG_END_COLOR: begin
          end_nxt = cfg_data;
          reinit  = 1'b1;
        end
        REG_FINAL_COLOR: final_nxt = cfg_data;
        REG_SPEED:       speed_nxt = cfg_data[SPEED_W-1:0];
        REG_LOOP_ENABLE: loop_nxt  = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Endpoint swap, end of fade and restart.
  always_comb begin
    from_nxt = from_r;
    to_nxt   = to_r;
    done_nxt = done_r;
    rev_nxt  = rev_r;
    priority if (reinit) begin
      from_nxt = start_nxt;
      to_nxt   = end_nxt;
      done_nxt = 1'b0;
    end else if (op == OP_ACCEPT) begin
      rev_nxt = 1'b0;
    end else if (op == OP_RESTART) begin
      done_nxt = 1'b0;
    end else if (op == OP_APPLY && reached) begin
      if (loop_r) begin
        from_nxt = to_r;
        to_nxt   = from_r;
        rev_nxt  = 1'b1;
      end else begin
        done_nxt = 1'b1;
      end
    end else begin
    end
  end

  // Color loaded into the lanes.
  always_comb begin
    load_en    = 1'b1;
    load_color = START_COLOR_RST;
    priority if (!rst_n) begin
      load_color = START_COLOR_RST;
    end else if (reinit) begin
      load_color = start_nxt;
    end else if (op == OP_RESTART) begin
      load_color = from_r;
    end else if (op == OP_APPLY && reached) begin
      load_color = loop_r ? to_r : final_r;
    end else begin
      load_en = 1'b0;
    end
  end

  assign out_valid_nxt = emit_fire | (out_valid_r & ~out_ready);

  // Control and configuration state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= START_COLOR_RST;
      end_r       <= END_COLOR_RST;
      final_r     <= FINAL_COLOR_RST;
      speed_r     <= SPEED_RST;
      loop_r      <= LOOP_RST;
      from_r      <= START_COLOR_RST;
      to_r        <= END_COLOR_RST;
      done_r      <= 1'b0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      final_r     <= final_nxt;
      speed_r     <= speed_nxt;
      loop_r      <= loop_nxt;
      from_r      <= from_nxt;
      to_r        <= to_nxt;
      done_r      <= done_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Tick capture and the shared speed * elapsed product.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ms_r      <= in_elapsed_ms;
      restart_r <= in_restart;
    end
    if (op == OP_MUL_T) begin
      t_r <= T_W'(speed_r) * T_W'(ms_r);
    end
  end

  // Channel lanes, red first.
  for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
    rfr_lane u_lane (
      .clk       (clk),
      .op        (op),
      .from_byte (from_r[COLOR_W-1-BYTE_W*k -: BYTE_W]),
      .to_byte   (to_r[COLOR_W-1-BYTE_W*k -: BYTE_W]),
      .t_prod    (t_r),
      .load_en   (load_en),
      .load_byte (load_color[COLOR_W-1-BYTE_W*k -: BYTE_W]),
      .cur       (cur[k]),
      .at_target (at_target[k])
    );
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_red      <= cur[0][CH_W-1 -: BYTE_W];
      out_green    <= cur[1][CH_W-1 -: BYTE_W];
      out_blue     <= cur[2][CH_W-1 -: BYTE_W];
      out_alpha    <= cur[3][CH_W-1 -: BYTE_W];
      out_ended    <= done_r;
      out_reversed <= rev_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  // A result only appears right after the emit step.
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(op == OP_EMIT))
    else $error("result appeared without an emit step");

  // An ended fade never reports a swap in the same result.
  a_end_no_swap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_ended && out_reversed))
    else $error("result both ended and reversed");

  // A tick transfer always starts the program.
  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (op == OP_MUL_T))
    else $error("tick transfer did not start the sequence");
`endif

endmodule

`default_nettype wire
